/* rtl/bbps_pkg.sv */
// ============================================================================
// bbps_pkg
// Types and constants shared by the bidirectional byte pattern search block.
// ============================================================================
package bbps_pkg;

  // Fixed field widths of the streams
  localparam int DATA_BITS   = 8;
  localparam int POS_BITS    = 48;
  localparam int PAT_BYTES   = 16;
  localparam int LEN_BITS    = 5;
  localparam int CFG_BITS    = 64;

  // Configuration register indexes
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_PATTERN_LOW     = 2'd0;
  localparam cfg_index_t CFG_PATTERN_HIGH    = 2'd1;
  localparam cfg_index_t CFG_PATTERN_LENGTH  = 2'd2;
  localparam cfg_index_t CFG_SEARCH_BACKWARD = 2'd3;

  // Result status codes
  typedef enum logic [1:0] {
    ST_SEARCHING = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  // Current register settings as seen by the matcher
  typedef struct packed {
    logic [PAT_BYTES-1:0][DATA_BITS-1:0] pattern;
    logic [LEN_BITS-1:0]                 length_raw;
    logic                                backward;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic [DATA_BITS-1:0] data_byte;
    logic                 first_item;
    logic [POS_BITS-1:0]  start_position;
    logic                 end_of_data;
  } item_t;

  // One result item
  typedef struct packed {
    status_t             status;
    logic [POS_BITS-1:0] match_offset;
  } result_t;

endpackage

/* rtl/bidirectional_byte_pattern_search.sv */
// ============================================================================
// bidirectional_byte_pattern_search
// Scans a byte stream for the first occurrence of a 1 to 16 byte pattern.
// ============================================================================
// Usage: the configuration port sets the pattern, its length and the scan
// direction; write it only while no transfer is in flight. Each input
// transfer carries one data byte in scan order; in_tuser marks the first
// byte of a search (loading the start address from in_tdata) and in_tlast
// marks end of data, where no byte is carried. Every input transfer gives
// exactly one output transfer: searching, found with the address of the
// match's lowest byte, not found, or ignored once the search has finished.
// The item waits in the input register, then the window compare writes the
// result register once that register is free or being emptied. Throughput
// is one item per cycle while the receiver takes the results, set by the
// combinational compare of the whole window against the pattern. When the
// receiver stalls, the result register holds, the input register takes one
// more item and in_tready then drops until the result is taken. Synchronous
// reset clears the window, the scan position, the search state and both
// stages, and sets the pattern length to one and the direction to forward.
// ============================================================================
module bidirectional_byte_pattern_search
  import bbps_pkg::*;
#(
  parameter int MAX_PATTERN  = 16,
  parameter int ADDRESS_BITS = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration write port
  input  logic                cfg_we,
  input  cfg_index_t          cfg_addr,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  // Input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [55:0]         in_tdata,   // data_byte [7:0], start_position [55:8]
  input  logic                in_tuser,   // first_item
  input  logic                in_tlast,   // end_of_data
  // Result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [47:0]         out_tdata,  // match_offset [47:0]
  output logic [1:0]          out_tuser   // status [1:0]
);

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  result_t result;
  result_t result_r;
  logic    out_valid_r;
  logic    advance;

  bbps_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The held item moves on when the result register is free or being emptied
  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.data_byte      <= in_tdata[7:0];
      item_r.start_position <= in_tdata[55:8];
      item_r.first_item     <= in_tuser;
      item_r.end_of_data    <= in_tlast;
    end
  end

  bbps_matcher #(
    .MAX_PATTERN  (MAX_PATTERN),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_matcher (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item_en (advance),
    .item    (item_r),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r.match_offset;
  assign out_tuser  = result_r.status;

endmodule

/* rtl/bbps_cfg_regs.sv */
// ============================================================================
// bbps_cfg_regs
// Configuration register file: pattern bytes, pattern length and direction.
// ============================================================================
module bbps_cfg_regs
  import bbps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  cfg_index_t          cfg_addr,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  output cfg_t                cfg
);

  logic [CFG_BITS-1:0] pattern_low_r;
  logic [CFG_BITS-1:0] pattern_high_r;
  logic [LEN_BITS-1:0] pattern_length_r;
  logic                search_backward_r;

  // Register writes; each register keeps only its own width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r     <= '0;
      pattern_high_r    <= '0;
      pattern_length_r  <= LEN_BITS'(1);
      search_backward_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PATTERN_LOW:     pattern_low_r     <= cfg_wdata;
        CFG_PATTERN_HIGH:    pattern_high_r    <= cfg_wdata;
        CFG_PATTERN_LENGTH:  pattern_length_r  <= cfg_wdata[LEN_BITS-1:0];
        CFG_SEARCH_BACKWARD: search_backward_r <= cfg_wdata[0];
      endcase
    end
  end

  // Byte i of the pattern sits in bits 8i+7 to 8i of the low and high words
  assign cfg.pattern    = {pattern_high_r, pattern_low_r};
  assign cfg.length_raw = pattern_length_r;
  assign cfg.backward   = search_backward_r;

endmodule

/* rtl/bbps_matcher.sv */
// ============================================================================
// bbps_matcher
// Search state, byte window and parallel pattern compare for one item.
// ============================================================================
module bbps_matcher
  import bbps_pkg::*;
#(
  parameter int MAX_PATTERN  = 16,
  parameter int ADDRESS_BITS = 48
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    item_en,
  input  item_t   item,
  output result_t result
);

  localparam int SEEN_BITS = $clog2(MAX_PATTERN + 1);
  localparam int WIDE_BITS = (ADDRESS_BITS > POS_BITS) ? ADDRESS_BITS : POS_BITS;

  logic [MAX_PATTERN-1:0][DATA_BITS-1:0] window_r, window_nxt;
  logic [SEEN_BITS-1:0]                  seen_r, seen_nxt;
  logic [ADDRESS_BITS-1:0]               pos_r, pos_nxt;
  logic                                  done_r, done_nxt;

  logic [LEN_BITS-1:0]     len_eff;
  logic [LEN_BITS-1:0]     pat_idx;
  logic [WIDE_BITS-1:0]    start_wide;
  logic [WIDE_BITS-1:0]    offset_wide;
  logic [ADDRESS_BITS-1:0] addr;
  logic                    hit;

  // Pattern length limited to the range one to MAX_PATTERN
  always_comb begin
    len_eff = cfg.length_raw;
    if (len_eff == '0) begin
      len_eff = LEN_BITS'(1);
    end
    if (len_eff > LEN_BITS'(MAX_PATTERN)) begin
      len_eff = LEN_BITS'(MAX_PATTERN);
    end
  end

  // Next state and result for the item in the input register
  always_comb begin
    window_nxt  = window_r;
    seen_nxt    = seen_r;
    pos_nxt     = pos_r;
    done_nxt    = done_r;
    addr        = pos_r;
    hit         = 1'b0;
    pat_idx     = '0;
    start_wide  = WIDE_BITS'(item.start_position);
    offset_wide = '0;
    result.status       = ST_SEARCHING;
    result.match_offset = '0;

    // A new search clears the window and loads the scan position
    if (item.first_item) begin
      window_nxt = '0;
      seen_nxt   = '0;
      pos_nxt    = start_wide[ADDRESS_BITS-1:0];
      done_nxt   = 1'b0;
    end

    if (!item.first_item && done_r) begin
      result.status = ST_IGNORED;
    end else if (item.end_of_data) begin
      done_nxt      = 1'b1;
      result.status = ST_NOT_FOUND;
    end else begin
      // Address of this byte and the position for the next one
      if (cfg.backward) begin
        addr    = pos_nxt - ADDRESS_BITS'(1);
        pos_nxt = addr;
      end else begin
        addr    = pos_nxt;
        pos_nxt = pos_nxt + ADDRESS_BITS'(1);
      end

      // Shift the newest byte into entry zero
      for (int k = MAX_PATTERN - 1; k > 0; k--) begin
        window_nxt[k] = window_nxt[k-1];
      end
      window_nxt[0] = item.data_byte;
      if (seen_nxt < SEEN_BITS'(MAX_PATTERN)) begin
        seen_nxt = seen_nxt + SEEN_BITS'(1);
      end

      // Parallel compare of all window entries in use
      hit = (LEN_BITS'(seen_nxt) >= len_eff);
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (LEN_BITS'(k) < len_eff) begin
          if (cfg.backward) begin
            pat_idx = LEN_BITS'(k);
          end else begin
            pat_idx = len_eff - LEN_BITS'(1) - LEN_BITS'(k);
          end
          if (window_nxt[k] != cfg.pattern[pat_idx[3:0]]) begin
            hit = 1'b0;
          end
        end
      end

      if (hit) begin
        done_nxt      = 1'b1;
        result.status = ST_FOUND;
        if (cfg.backward) begin
          offset_wide = WIDE_BITS'(addr);
        end else begin
          offset_wide = WIDE_BITS'(addr - ADDRESS_BITS'(len_eff) + ADDRESS_BITS'(1));
        end
        result.match_offset = offset_wide[POS_BITS-1:0];
      end
    end
  end

  // Search state registers, updated once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      seen_r   <= '0;
      pos_r    <= '0;
      done_r   <= 1'b0;
    end else if (item_en) begin
      window_r <= window_nxt;
      seen_r   <= seen_nxt;
      pos_r    <= pos_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule
